[rtl/ewss_pkg.sv]
// Shared types, widths and constants of the seeded exponential moving average block.
`timescale 1ns / 1ps

package ewss_pkg;

    // Field and register widths.
    localparam int PRICE_W     = 32;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 9;
    localparam int NUM_W       = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    // Fixed-point formats: factor Q1.16, kept average Q24.24.
    localparam int FRAC_EXTRA  = 16;
    localparam int FACTOR_W    = 17;
    localparam int ACC_W       = PRICE_W + FRAC_EXTRA;

    localparam logic [FACTOR_W-1:0] ONE_Q16  = FACTOR_W'(1 << FRAC_EXTRA);
    localparam logic [FACTOR_W-1:0] HALF_Q16 = FACTOR_W'(1 << (FRAC_EXTRA - 1));
    localparam logic [ACC_W-1:0]    ACC_CAP  = {{PRICE_W{1'b1}}, {FRAC_EXTRA{1'b0}}};

    // Default of the largest window the seed sum is sized for.
    localparam int DEF_MAX_WINDOW = 256;

    // Register indexes and their reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING    = 1'b1;
    localparam logic [WIN_W-1:0]       AVERAGE_SIZE_RST = 9'd20;
    localparam logic [NUM_W-1:0]       SMOOTHING_RST    = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_FSTART,
        S_FWAIT,
        S_FSTORE,
        S_IDLE,
        S_GATHER,
        S_CHECK,
        S_SSTART,
        S_SWAIT,
        S_SSTORE,
        S_MLO,
        S_MHI,
        S_MCLOSE,
        S_MFIN,
        S_EMIT
    } ctrl_state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ADD,
        OP_FACTOR_LOAD,
        OP_FACTOR_STORE,
        OP_SEED_LOAD,
        OP_SEED_STORE,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_CLOSE,
        OP_MUL_FIN,
        OP_EMIT
    } dp_op_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic seeded;
        logic count_full;
        logic div_done;
        logic out_free;
        logic cfg_hit;
    } dp_status_t;

endpackage

[rtl/ewss_in_if.sv]
// Input channel: one bar close price and bar time per word.
`timescale 1ns / 1ps

interface ewss_in_if;
    logic                         valid;
    logic                         ready;
    logic [ewss_pkg::PRICE_W-1:0] close_price;
    logic [ewss_pkg::TIME_W-1:0]  bar_time;

    modport source (output valid, output close_price, output bar_time, input ready);
    modport sink   (input valid, input close_price, input bar_time, output ready);
endinterface

[rtl/ewss_out_if.sv]
// Output channel: one average value, its bar time and the seed flag per word.
`timescale 1ns / 1ps

interface ewss_out_if;
    logic                         valid;
    logic                         ready;
    logic [ewss_pkg::PRICE_W-1:0] average_value;
    logic [ewss_pkg::TIME_W-1:0]  result_time;
    logic                         is_seed;

    modport source (output valid, output average_value, output result_time,
                    output is_seed, input ready);
    modport sink   (input valid, input average_value, input result_time,
                    input is_seed, output ready);
endinterface

[rtl/ewss_div.sv]
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module ewss_div #(
    parameter int DIVIDEND_W = 57,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0] work_reg,  work_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg,   dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One shift and trial subtract per cycle; the remainder stays below the divisor.
    always_comb
    begin
        trial     = {rem_reg, work_reg[DIVIDEND_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[rtl/ewss_datapath.sv]
// Datapath: configuration registers, seed sum, kept average, multiplier and output register.
`timescale 1ns / 1ps

module ewss_datapath #(
    parameter int MAX_WINDOW = ewss_pkg::DEF_MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ewss_pkg::dp_op_t                 op,
    input  logic                             cfg_write,
    input  logic [ewss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ewss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [ewss_pkg::PRICE_W-1:0]     in_close,
    input  logic [ewss_pkg::TIME_W-1:0]      in_time,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [ewss_pkg::PRICE_W-1:0]     out_value,
    output logic [ewss_pkg::TIME_W-1:0]      out_time,
    output logic                             out_seed,
    output ewss_pkg::dp_status_t             status
);

    localparam int PRICE_W  = ewss_pkg::PRICE_W;
    localparam int WIN_W    = ewss_pkg::WIN_W;
    localparam int NUM_W    = ewss_pkg::NUM_W;
    localparam int FACTOR_W = ewss_pkg::FACTOR_W;
    localparam int ACC_W    = ewss_pkg::ACC_W;
    localparam int FRAC_X   = ewss_pkg::FRAC_EXTRA;
    localparam int SUM_W    = PRICE_W + $clog2(MAX_WINDOW + 1);
    localparam int DIV_W    = SUM_W + FRAC_X;
    localparam int DVS_W    = WIN_W + 2;
    localparam int PROD_W   = PRICE_W + FACTOR_W;
    localparam int MAC_W    = ACC_W + FACTOR_W + 1;
    localparam int LO_W     = ACC_W / 2;
    localparam int WIN_MAX  = (1 << WIN_W) - 1;
    localparam int WIN_CAP  = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
    localparam logic [WIN_W-1:0] WIN_CAP_V = WIN_W'(WIN_CAP);

    logic [WIN_W-1:0]    avg_reg,     avg_next;
    logic [NUM_W-1:0]    num_reg,     num_next;
    logic [WIN_W-1:0]    count_reg,   count_next;
    logic [SUM_W-1:0]    sum_reg,     sum_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic                seeded_reg,  seeded_next;
    logic                out_valid_reg, out_valid_next;
    logic [FACTOR_W-1:0] factor_reg;
    logic [PRICE_W-1:0]  close_reg;
    logic [ewss_pkg::TIME_W-1:0] time_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic                emit_seed_reg;
    logic [PRICE_W-1:0]  out_value_reg;
    logic [ewss_pkg::TIME_W-1:0] out_time_reg;
    logic                out_seed_reg;

    logic [WIN_W-1:0]    win_used;
    logic [NUM_W-1:0]    num_used;
    logic [WIN_W:0]      win_plus;
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic [FACTOR_W-1:0] gain;
    logic [PRICE_W-1:0]  mul_a;
    logic [FACTOR_W-1:0] mul_b;
    logic [PROD_W-1:0]   product;
    logic [MAC_W-FRAC_X-1:0] mac_scaled;
    logic [ACC_W:0]      rounded;
    logic [PRICE_W:0]    value_wide;
    logic                out_free;

    // Window and numerator as used, with out-of-range codes pulled into range.
    always_comb
    begin
        if (avg_reg == '0)
            win_used = WIN_W'(1);
        else if (avg_reg > WIN_CAP_V)
            win_used = WIN_CAP_V;
        else
            win_used = avg_reg;
        if (num_reg == '0)
            num_used = NUM_W'(1);
        else if (num_reg == NUM_W'(3))
            num_used = NUM_W'(2);
        else
            num_used = num_reg;
        win_plus = {1'b0, win_used} + (WIN_W + 1)'(1);
    end

    // Shared divider: smoothing factor when idle, seed mean on the window's last close.
    always_comb
    begin
        div_start = (op == ewss_pkg::OP_FACTOR_LOAD) || (op == ewss_pkg::OP_SEED_LOAD);
        if (op == ewss_pkg::OP_SEED_LOAD)
        begin
            div_dividend = (DIV_W'(sum_reg) << FRAC_X) + DIV_W'(win_used >> 1);
            div_divisor  = DVS_W'(win_used);
        end
        else
        begin
            div_dividend = (DIV_W'(num_used) << FACTOR_W) + DIV_W'(win_plus);
            div_divisor  = {win_plus, 1'b0};
        end
    end

    ewss_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // One 32 by 17 multiplier, stepped over the low half, high half and the close.
    always_comb
    begin
        gain = ewss_pkg::ONE_Q16 - factor_reg;
        case (op)
            ewss_pkg::OP_MUL_LO:
            begin
                mul_a = PRICE_W'(acc_reg[LO_W-1:0]);
                mul_b = gain;
            end
            ewss_pkg::OP_MUL_HI:
            begin
                mul_a = PRICE_W'(acc_reg[ACC_W-1:LO_W]);
                mul_b = gain;
            end
            default:
            begin
                mul_a = close_reg;
                mul_b = factor_reg;
            end
        endcase
        product    = PROD_W'(mul_a) * PROD_W'(mul_b);
        mac_scaled = mac_reg[MAC_W-1:FRAC_X];
    end

    // Rounded, saturated output value from the kept average.
    always_comb
    begin
        rounded    = {1'b0, acc_reg} + (ACC_W + 1)'(ewss_pkg::HALF_Q16);
        value_wide = rounded[ACC_W:FRAC_X];
        out_free   = !out_valid_reg || out_ready;
    end

    // Next values of the run state and the output handshake.
    always_comb
    begin
        avg_next       = avg_reg;
        num_next       = num_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            ewss_pkg::OP_ADD:
            begin
                sum_next   = sum_reg + SUM_W'(close_reg);
                count_next = count_reg + WIN_W'(1);
            end
            ewss_pkg::OP_SEED_STORE:
            begin
                acc_next    = (div_q > DIV_W'(ewss_pkg::ACC_CAP)) ?
                              ewss_pkg::ACC_CAP : div_q[ACC_W-1:0];
                seeded_next = 1'b1;
            end
            ewss_pkg::OP_MUL_FIN:
            begin
                acc_next = (mac_scaled > (MAC_W - FRAC_X)'(ewss_pkg::ACC_CAP)) ?
                           ewss_pkg::ACC_CAP : mac_scaled[ACC_W-1:0];
            end
            ewss_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        // A window write starts a fresh seed.
        if (cfg_write)
        begin
            if (cfg_index == ewss_pkg::CFG_AVERAGE_SIZE)
            begin
                avg_next    = cfg_data[WIN_W-1:0];
                count_next  = '0;
                sum_next    = '0;
                acc_next    = '0;
                seeded_next = 1'b0;
            end
            else if (cfg_index == ewss_pkg::CFG_SMOOTHING)
            begin
                num_next = cfg_data[NUM_W-1:0];
            end
        end
    end

    // Configuration and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= ewss_pkg::AVERAGE_SIZE_RST;
            num_reg       <= ewss_pkg::SMOOTHING_RST;
            count_reg     <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            avg_reg       <= avg_next;
            num_reg       <= num_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            acc_reg       <= acc_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: captured word, factor, product sum and output word.
    // The seed flag of the word being worked on is moved to the output only on emit,
    // so a waiting output word keeps its flag.
    always_ff @(posedge clk)
    begin
        case (op)
            ewss_pkg::OP_CAPTURE:
            begin
                close_reg <= in_close;
                time_reg  <= in_time;
            end
            ewss_pkg::OP_FACTOR_STORE:
            begin
                factor_reg <= div_q[FACTOR_W-1:0];
            end
            ewss_pkg::OP_SEED_STORE:
            begin
                emit_seed_reg <= 1'b1;
            end
            ewss_pkg::OP_MUL_LO:
            begin
                mac_reg       <= MAC_W'(ewss_pkg::HALF_Q16) + MAC_W'(product);
                emit_seed_reg <= 1'b0;
            end
            ewss_pkg::OP_MUL_HI:
            begin
                mac_reg <= mac_reg + (MAC_W'(product) << LO_W);
            end
            ewss_pkg::OP_MUL_CLOSE:
            begin
                mac_reg <= mac_reg + (MAC_W'(product) << FRAC_X);
            end
            ewss_pkg::OP_EMIT:
            begin
                out_value_reg <= value_wide[PRICE_W] ? {PRICE_W{1'b1}} :
                                 value_wide[PRICE_W-1:0];
                out_time_reg  <= time_reg;
                out_seed_reg  <= emit_seed_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_time  = out_time_reg;
    assign out_seed  = out_seed_reg;

    assign status.seeded     = seeded_reg;
    assign status.count_full = (count_reg >= win_used);
    assign status.div_done   = div_done;
    assign status.out_free   = out_free;
    assign status.cfg_hit    = cfg_write;

endmodule

[rtl/ewss_ctrl.sv]
// Controller state machine that sequences the datapath for each word.
`timescale 1ns / 1ps

module ewss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ewss_pkg::dp_status_t status,
    output logic                 in_ready,
    output ewss_pkg::dp_op_t     op
);

    ewss_pkg::ctrl_state_t state_reg, state_next;
    logic                  dirty_reg, dirty_next;
    logic                  idle_ready;

    // A register write marks the factor stale until it is recomputed.
    always_comb
    begin
        idle_ready = (state_reg == ewss_pkg::S_IDLE) && !dirty_reg && !status.cfg_hit;
        dirty_next = dirty_reg || status.cfg_hit;
        if ((state_reg == ewss_pkg::S_FSTART) && !status.cfg_hit)
            dirty_next = 1'b0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ewss_pkg::S_FSTART: state_next = ewss_pkg::S_FWAIT;
            ewss_pkg::S_FWAIT:
                if (status.div_done)
                    state_next = ewss_pkg::S_FSTORE;
            ewss_pkg::S_FSTORE: state_next = ewss_pkg::S_IDLE;
            ewss_pkg::S_IDLE:
                if (dirty_reg || status.cfg_hit)
                    state_next = ewss_pkg::S_FSTART;
                else if (in_valid)
                    state_next = ewss_pkg::S_GATHER;
            ewss_pkg::S_GATHER:
                state_next = status.seeded ? ewss_pkg::S_MLO : ewss_pkg::S_CHECK;
            ewss_pkg::S_CHECK:
                state_next = status.count_full ? ewss_pkg::S_SSTART : ewss_pkg::S_IDLE;
            ewss_pkg::S_SSTART: state_next = ewss_pkg::S_SWAIT;
            ewss_pkg::S_SWAIT:
                if (status.div_done)
                    state_next = ewss_pkg::S_SSTORE;
            ewss_pkg::S_SSTORE: state_next = ewss_pkg::S_EMIT;
            ewss_pkg::S_MLO:    state_next = ewss_pkg::S_MHI;
            ewss_pkg::S_MHI:    state_next = ewss_pkg::S_MCLOSE;
            ewss_pkg::S_MCLOSE: state_next = ewss_pkg::S_MFIN;
            ewss_pkg::S_MFIN:   state_next = ewss_pkg::S_EMIT;
            ewss_pkg::S_EMIT:
                if (status.out_free)
                    state_next = ewss_pkg::S_IDLE;
            default:            state_next = ewss_pkg::S_FSTART;
        endcase
    end

    // Outputs: handshake ready and the datapath operation of this cycle.
    always_comb
    begin
        in_ready = idle_ready;
        op       = ewss_pkg::OP_NONE;
        case (state_reg)
            ewss_pkg::S_FSTART: op = ewss_pkg::OP_FACTOR_LOAD;
            ewss_pkg::S_FSTORE: op = ewss_pkg::OP_FACTOR_STORE;
            ewss_pkg::S_IDLE:
                if (idle_ready && in_valid)
                    op = ewss_pkg::OP_CAPTURE;
            ewss_pkg::S_GATHER:
                if (!status.seeded)
                    op = ewss_pkg::OP_ADD;
            ewss_pkg::S_SSTART: op = ewss_pkg::OP_SEED_LOAD;
            ewss_pkg::S_SSTORE: op = ewss_pkg::OP_SEED_STORE;
            ewss_pkg::S_MLO:    op = ewss_pkg::OP_MUL_LO;
            ewss_pkg::S_MHI:    op = ewss_pkg::OP_MUL_HI;
            ewss_pkg::S_MCLOSE: op = ewss_pkg::OP_MUL_CLOSE;
            ewss_pkg::S_MFIN:   op = ewss_pkg::OP_MUL_FIN;
            ewss_pkg::S_EMIT:
                if (status.out_free)
                    op = ewss_pkg::OP_EMIT;
            default:            op = ewss_pkg::OP_NONE;
        endcase
    end

    // State registers; after reset the factor is worked out first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ewss_pkg::S_FSTART;
            dirty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
        end
    end

endmodule

[rtl/ema_with_sma_seed.sv]
// Top level of the exponential moving average of bar closes, seeded with a simple mean.
`timescale 1ns / 1ps

// Usage: in_ch carries one word per bar (close_price in Q24.8, bar_time). The first
// average_size - 1 words give no result; the next one gives the simple mean of the
// window with is_seed high, and each later word gives one EMA value with is_seed low,
// on out_ch, carrying the bar_time of the word that produced it.
// Configuration: cfg_write with cfg_index 0 sets the window (and restarts the seed),
// index 1 sets the smoothing numerator. Write only while no word is in flight.
// The smoothing factor goes through the bit-serial divider after reset and after every
// register write, with a dividend W = 32 + clog2(MAX_WINDOW + 1) + 16 bits wide;
// in_ch.ready stays low meanwhile.
// A word gathered toward the seed is captured, added to the seed sum and checked. The
// seed word then goes through the same divider for the mean. An EMA word goes through
// the one 32 by 17 multiplier stepped over three partial products.
// Reset clears the run, loads window 20 and numerator 2, and starts the factor.
// A result waits in the output register while out_ch.ready is low; the next word is
// still taken and worked on, and only its own result waits for the register to free.
module ema_with_sma_seed #(
    parameter int MAX_WINDOW = ewss_pkg::DEF_MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ewss_in_if.sink                          in_ch,
    ewss_out_if.source                       out_ch,
    input  logic                             cfg_write,
    input  logic [ewss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ewss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ewss_pkg::dp_op_t     op;
    ewss_pkg::dp_status_t status;
    logic                 in_ready;

    // Sequencer.
    ewss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    // Arithmetic and storage.
    ewss_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_close  (in_ch.close_price),
        .in_time   (in_ch.bar_time),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_value (out_ch.average_value),
        .out_time  (out_ch.result_time),
        .out_seed  (out_ch.is_seed),
        .status    (status)
    );

    assign in_ch.ready = in_ready;

endmodule

[tb/sv/tb_ema_with_sma_seed.sv]
// Self-checking testbench for the seeded exponential moving average of bar closes.
`timescale 1ns / 1ps

module tb_ema_with_sma_seed;

    import ewss_pkg::*;

    localparam int          MAX_WIN        = DEF_MAX_WINDOW;
    localparam int unsigned TOTAL_BARS     = 1465;
    localparam int unsigned SETTLE_CYCLES  = 120;
    localparam int unsigned LONG_HOLD      = 500;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned PRINT_LIMIT    = 100;

    // Gap styles for either side of the block.
    localparam int unsigned GAP_NONE   = 0;
    localparam int unsigned GAP_RANDOM = 1;
    localparam int unsigned GAP_SPARSE = 2;

    typedef struct packed {
        logic [PRICE_W-1:0] close;
        logic [TIME_W-1:0]  stamp;
    } bar_t;

    typedef struct packed {
        logic [PRICE_W-1:0] value;
        logic [TIME_W-1:0]  stamp;
        logic               seed;
    } ema_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ewss_in_if  bar_ch ();
    ewss_out_if avg_ch ();

    ema_with_sma_seed #(
        .MAX_WINDOW (MAX_WIN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (bar_ch),
        .out_ch    (avg_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bars waiting to be sent and averages still owed by the block.
    bar_t        bar_queue[$];
    ema_result_t ema_expected[$];

    // Predictor copy of the registers and the running state.
    logic [WIN_W-1:0]    win_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [FACTOR_W-1:0] alpha_q16;
    int unsigned         gathered;
    logic [47:0]         seed_total;
    logic [ACC_W-1:0]    ema_keep;
    logic                have_seed;

    int unsigned bars_queued    = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_mode        = GAP_NONE;
    int unsigned rx_mode        = GAP_NONE;
    int unsigned tx_gap         = 0;
    int unsigned rx_stall       = 0;
    int unsigned idle_cycles    = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_started  = 0;
    int unsigned rx_hold_left   = 0;
    logic        bar_fired      = 1'b0;
    logic        avg_fired      = 1'b0;

    always #1 clk = ~clk;

    // Window length as the block uses it.
    function automatic int unsigned window_in_use(input logic [WIN_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_WIN)
            return MAX_WIN;
        return w;
    endfunction

    // Smoothing factor in Q1.16, rounded half up.
    function automatic logic [FACTOR_W-1:0] calc_factor(input logic [WIN_W-1:0] w,
                                                        input logic [NUM_W-1:0] s);
        int unsigned num;
        int unsigned den;
        num = (s == 2'd0) ? 1 : ((s == 2'd3) ? 2 : s);
        den = window_in_use(w) + 1;
        return FACTOR_W'((num * 131072 + den) / (2 * den));
    endfunction

    function automatic int unsigned draw_gap(input int unsigned mode);
        if (mode == GAP_NONE)
            return 0;
        if (mode == GAP_RANDOM)
            return $urandom_range(0, 15);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endfunction

    // Closes mostly wander around a level, with extremes and full-range values mixed in.
    function automatic logic [PRICE_W-1:0] rand_close(input logic [PRICE_W-1:0] level);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return '0;
            2:       return '1;
            default: return level + $urandom_range(0, 8191) - 32'd4096;
        endcase
    endfunction

    task automatic ema_clear();
        gathered   = 0;
        seed_total = '0;
        ema_keep   = '0;
        have_seed  = 1'b0;
    endtask

    // Advance the predictor by one bar and queue the average it produces, if any.
    task automatic ema_step(input logic [PRICE_W-1:0] close, input logic [TIME_W-1:0] stamp);
        logic [79:0]  wide;
        int unsigned  n;
        ema_result_t  r;
        n = window_in_use(win_reg);
        if (!have_seed)
        begin
            seed_total = seed_total + close;
            gathered   = gathered + 1;
            if (gathered < n)
                return;
            wide = ((80'(seed_total) << FRAC_EXTRA) + 80'(n / 2)) / 80'(n);
            r.seed = 1'b1;
        end
        else
        begin
            wide = 80'(ema_keep) * (ONE_Q16 - alpha_q16)
                 + (80'(close) << FRAC_EXTRA) * alpha_q16 + HALF_Q16;
            wide = wide >> FRAC_EXTRA;
            r.seed = 1'b0;
        end
        if (wide > 80'(ACC_CAP))
            wide = 80'(ACC_CAP);
        ema_keep  = wide[ACC_W-1:0];
        have_seed = 1'b1;

        // Round the kept value back to Q24.8 and saturate.
        wide = (80'(ema_keep) + HALF_Q16) >> FRAC_EXTRA;
        if (wide > 80'hFFFF_FFFF)
            wide = 80'hFFFF_FFFF;
        r.value = wide[PRICE_W-1:0];
        r.stamp = stamp;
        ema_expected = {ema_expected, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_bar(input logic [PRICE_W-1:0] close, input logic [TIME_W-1:0] stamp);
        bar_t b;
        b.close = close;
        b.stamp = stamp;
        bar_queue = {bar_queue, b};
        bars_queued++;
    endtask

    // Register write, preceded by a pause so that the block has finished any bar.
    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_AVERAGE_SIZE)
        begin
            win_reg = data[WIN_W-1:0];
            ema_clear();
        end
        else
        begin
            num_reg = data[NUM_W-1:0];
        end
        alpha_q16 = calc_factor(win_reg, num_reg);
    endtask

    // Hold the sender until every queued bar is taken and every average has come back.
    task automatic wait_idle();
        while (bar_queue.size() != 0 || bar_ch.valid || ema_expected.size() != 0)
            @(posedge clk);
    endtask

    // Sample both handshakes, check results and feed the predictor.
    always @(posedge clk)
    begin : word_monitor
        ema_result_t want;
        bar_fired <= (bar_ch.valid === 1'b1) && (bar_ch.ready === 1'b1);
        avg_fired <= (avg_ch.valid === 1'b1) && (avg_ch.ready === 1'b1);
        if (avg_ch.valid === 1'b1 && avg_ch.ready === 1'b1)
        begin
            if (ema_expected.size() == 0)
            begin
                report_mismatch("unexpected word, average_value", avg_ch.average_value, '0);
            end
            else
            begin
                want = ema_expected.pop_front();
                if (avg_ch.average_value !== want.value)
                    report_mismatch("average_value", avg_ch.average_value, want.value);
                if (avg_ch.result_time !== want.stamp)
                    report_mismatch("result_time", avg_ch.result_time, want.stamp);
                if (avg_ch.is_seed !== want.seed)
                    report_mismatch("is_seed", 32'(avg_ch.is_seed), 32'(want.seed));
            end
        end
        if (bar_ch.valid === 1'b1 && bar_ch.ready === 1'b1)
            ema_step(bar_ch.close_price, bar_ch.bar_time);
    end

    // Bar driver: holds a word until it is taken, then waits its drawn gap.
    always @(negedge clk)
    begin : bar_driver
        bar_t next_bar;
        if (!bar_ch.valid || bar_fired)
        begin
            if (tx_gap != 0)
            begin
                bar_ch.valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (bar_queue.size() != 0)
            begin
                next_bar = bar_queue.pop_front();
                bar_ch.valid       <= 1'b1;
                bar_ch.close_price <= next_bar.close;
                bar_ch.bar_time    <= next_bar.stamp;
                tx_gap <= draw_gap(tx_mode);
            end
            else
            begin
                bar_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: stalls for a drawn number of cycles after each word, and on request
    // holds off for a long stretch that it counts itself.
    always @(negedge clk)
    begin : result_sink
        int unsigned hold;
        if (holds_started != hold_requests)
        begin
            avg_ch.ready  <= 1'b0;
            rx_hold_left  <= LONG_HOLD - 1;
            holds_started <= holds_started + 1;
        end
        else if (rx_hold_left != 0)
        begin
            avg_ch.ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (avg_fired)
        begin
            hold = draw_gap(rx_mode);
            if (hold == 0)
            begin
                avg_ch.ready <= 1'b1;
            end
            else
            begin
                avg_ch.ready <= 1'b0;
                rx_stall <= hold - 1;
            end
        end
        else if (rx_stall != 0)
        begin
            avg_ch.ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            avg_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if ((bar_ch.valid === 1'b1 && bar_ch.ready === 1'b1) ||
            (avg_ch.valid === 1'b1 && avg_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned        phase;
        int unsigned        count;
        int unsigned        pick;
        logic               keep_run;
        logic [WIN_W-1:0]   win;
        logic [CFG_DATA_W-1:0] num_data;
        logic [PRICE_W-1:0] level;
        logic [TIME_W-1:0]  stamp;

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        bar_ch.valid       = 1'b0;
        bar_ch.close_price = '0;
        bar_ch.bar_time    = '0;
        avg_ch.ready       = 1'b0;

        win_reg   = AVERAGE_SIZE_RST;
        num_reg   = SMOOTHING_RST;
        alpha_q16 = calc_factor(win_reg, num_reg);
        ema_clear();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Window of one with factor 1.0: the seed and every update follow the close.
        cfg_put(CFG_AVERAGE_SIZE, 9'd1);
        cfg_put(CFG_SMOOTHING, 9'd2);
        queue_bar(32'hFFFF_FFFF, 32'h0000_0000);
        queue_bar(32'h0000_0000, 32'hFFFF_FFFF);
        queue_bar(32'hFFFF_FFFF, 32'h0000_0001);
        queue_bar(32'h0000_0080, 32'h8000_0000);
        wait_idle();

        // Numerator zero acts as one; the run continues across the write.
        cfg_put(CFG_SMOOTHING, 9'h1FC);
        queue_bar(32'h0000_0000, 32'h0000_1000);
        queue_bar(32'hFFFF_FFFF, 32'h0000_2000);
        wait_idle();

        // Numerator three acts as two.
        cfg_put(CFG_SMOOTHING, 9'h003);
        queue_bar(32'h1234_5678, 32'h7FFF_FFFF);
        queue_bar(32'h0000_0001, 32'hAAAA_5555);
        wait_idle();

        // Window zero acts as one.
        cfg_put(CFG_AVERAGE_SIZE, 9'd0);
        queue_bar(32'h8000_0000, 32'h5555_AAAA);
        queue_bar(32'h7FFF_FFFF, 32'h0F0F_0F0F);
        wait_idle();

        // A window rewritten in the middle of gathering starts a fresh seed.
        cfg_put(CFG_AVERAGE_SIZE, 9'd3);
        queue_bar(32'hDEAD_BEEF, 32'h0000_0003);
        wait_idle();
        cfg_put(CFG_AVERAGE_SIZE, 9'd2);
        queue_bar(32'hFFFF_FFFF, 32'hF0F0_F0F0);
        queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_bar(32'h0000_0000, 32'h0000_0010);
        queue_bar(32'h0000_0001, 32'h0000_0020);
        wait_idle();

        // Random phases: a new setting each, mostly short windows, a few at the limit.
        phase = 0;
        while (bars_queued < TOTAL_BARS)
        begin
            phase++;
            wait_idle();
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            if (phase == 2)
                tx_mode = GAP_NONE;

            pick = $urandom_range(0, 19);
            if (phase == 3)
                win = '1;
            else if (phase == 8)
                win = 9'd256;
            else if (pick < 14)
                win = WIN_W'($urandom_range(1, 8));
            else if (pick < 18)
                win = WIN_W'($urandom_range(9, 40));
            else
                win = '0;
            num_data = CFG_DATA_W'($urandom);
            keep_run = (phase > 1) && (phase != 3) && (phase != 8) &&
                       ($urandom_range(0, 3) == 0);

            if (keep_run)
            begin
                cfg_put(CFG_SMOOTHING, num_data);
                count = $urandom_range(5, 40);
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                cfg_put(CFG_AVERAGE_SIZE, win);
                cfg_put(CFG_SMOOTHING, num_data);
                count = window_in_use(win) + $urandom_range(3, 40);
            end
            else
            begin
                cfg_put(CFG_SMOOTHING, num_data);
                cfg_put(CFG_AVERAGE_SIZE, win);
                count = window_in_use(win) + $urandom_range(3, 40);
            end

            level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom;
            stamp = $urandom;
            repeat (count)
            begin
                queue_bar(rand_close(level), stamp);
                stamp = stamp + (($urandom_range(0, 7) == 0) ? $urandom : 32'd60);
            end

            // Receiver holds off while bars keep coming, so the input backs up.
            if (phase == 2)
                hold_requests++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
